FILE: rtl/assert_macros.svh
// Assertion helpers used by the loader parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/srec_pkg.sv
// ----------------------------------------------------------------------------
// S-record loader package
// Item types, parse codes and character constants shared by the loader.
// ----------------------------------------------------------------------------
package srec_pkg;

   localparam int LINE_LIMIT_DEFAULT = 127;
   localparam int LINE_POS_W = 8;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_S = 8'h53;
   localparam logic [7:0] CHAR_0 = 8'h30;
   localparam logic [7:0] CHAR_1 = 8'h31;
   localparam logic [7:0] CHAR_5 = 8'h35;
   localparam logic [7:0] CHAR_9 = 8'h39;
   localparam logic [7:0] COUNT_OVERHEAD = 8'd3;

   typedef enum logic [0:0] {
      REQ_CHAR  = 1'b0,
      REQ_START = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      EV_WRITE = 2'd0,
      EV_ACK   = 2'd1,
      EV_OK    = 2'd2,
      EV_FAIL  = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      STAGE_S     = 3'd0,
      STAGE_TYPE  = 3'd1,
      STAGE_COUNT = 3'd2,
      STAGE_ADDR  = 3'd3,
      STAGE_DATA  = 3'd4,
      STAGE_CHECK = 3'd5,
      STAGE_DONE  = 3'd6
   } stage_type;

   typedef enum logic [1:0] {
      KIND_S0 = 2'd0,
      KIND_S1 = 2'd1,
      KIND_S5 = 2'd2,
      KIND_S9 = 2'd3
   } kind_type;

   typedef struct packed {
      logic [0:0] req_type;
      logic [7:0] character;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [15:0] write_address;
      logic [7:0]  write_data;
      logic [15:0] entry_address;
   } rsp_item_type;

endpackage

FILE: rtl/srec_in_stage.sv
// ----------------------------------------------------------------------------
// S-record loader input register
// Holds one incoming item until the parser consumes it.
// ----------------------------------------------------------------------------
module srec_in_stage import srec_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   input  logic         consume,
   output logic         held_valid,
   output req_item_type held_item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign req_ready = !valid_ff || consume;
   assign held_valid = valid_ff;
   assign held_item = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

FILE: rtl/srec_parser.sv
// ----------------------------------------------------------------------------
// S-record loader parser
// Line and record state, updated once for each consumed item.
// ----------------------------------------------------------------------------
module srec_parser import srec_pkg::*; #(
   parameter int LINE_LIMIT = LINE_LIMIT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   output logic         res_valid,
   output rsp_item_type res_item
);

   `include "assert_macros.svh"

   localparam logic [LINE_POS_W-1:0] LIMIT_C = LINE_POS_W'(LINE_LIMIT);

   logic                  active_ff, active_in;
   logic [LINE_POS_W-1:0] pos_ff, pos_in;
   stage_type             stage_ff, stage_in;
   kind_type              kind_ff, kind_in;
   logic [3:0]            nibble_ff, nibble_in;
   logic                  pending_ff, pending_in;
   logic [7:0]            length_ff, length_in;
   logic [7:0]            sum_ff, sum_in;
   logic [15:0]           addr_ff, addr_in;
   logic [7:0]            left_ff, left_in;
   logic [1:0]            seen_ff, seen_in;
   logic                  failed_ff, failed_in;

   logic       is_start;
   logic       char_step;
   logic       is_eol;
   logic       keep_char;
   logic       parsing;
   logic       hex_ok;
   logic [3:0] hex_val;
   logic       byte_done;
   logic [7:0] byte_val;
   logic       line_bad;
   logic [7:0] left_next;

   always_comb begin
      hex_ok = 1'b1;
      hex_val = 4'd0;
      if (item.character >= 8'h30 && item.character <= 8'h39) begin
         hex_val = item.character[3:0];
      end else if ((item.character >= 8'h41 && item.character <= 8'h46)
                   || (item.character >= 8'h61 && item.character <= 8'h66)) begin
         hex_val = item.character[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign is_start = step && (item.req_type == REQ_START);
   assign char_step = step && (item.req_type == REQ_CHAR) && active_ff;
   assign is_eol = (item.character == CHAR_CR) || (item.character == CHAR_LF);
   assign keep_char = char_step && !is_eol && (pos_ff < LIMIT_C);
   assign parsing = keep_char && !failed_ff && (stage_ff != STAGE_DONE);
   assign byte_done = parsing && (stage_ff != STAGE_S) && (stage_ff != STAGE_TYPE)
                      && hex_ok && pending_ff;
   assign byte_val = {nibble_ff, hex_val};
   assign line_bad = failed_ff || (stage_ff != STAGE_DONE);
   assign left_next = length_ff - COUNT_OVERHEAD;

   always_comb begin
      active_in = active_ff;
      pos_in = pos_ff;
      stage_in = stage_ff;
      kind_in = kind_ff;
      nibble_in = nibble_ff;
      pending_in = pending_ff;
      length_in = length_ff;
      sum_in = sum_ff;
      addr_in = addr_ff;
      left_in = left_ff;
      seen_in = seen_ff;
      failed_in = failed_ff;
      if (is_start || (char_step && is_eol && (pos_ff != '0))) begin
         if (is_start) begin
            active_in = 1'b1;
         end else if (line_bad || (kind_ff == KIND_S9)) begin
            active_in = 1'b0;
         end
         pos_in = '0;
         stage_in = STAGE_S;
         kind_in = KIND_S0;
         nibble_in = '0;
         pending_in = 1'b0;
         length_in = '0;
         sum_in = '0;
         addr_in = '0;
         left_in = '0;
         seen_in = '0;
         failed_in = 1'b0;
      end else if (keep_char) begin
         pos_in = pos_ff + LINE_POS_W'(1);
         if (parsing) begin
            if (stage_ff == STAGE_S) begin
               if (item.character == CHAR_S) begin
                  stage_in = STAGE_TYPE;
               end else begin
                  failed_in = 1'b1;
               end
            end else if (stage_ff == STAGE_TYPE) begin
               priority if (item.character == CHAR_0) begin
                  kind_in = KIND_S0;
                  stage_in = STAGE_DONE;
               end else if (item.character == CHAR_5) begin
                  kind_in = KIND_S5;
                  stage_in = STAGE_DONE;
               end else if (item.character == CHAR_1) begin
                  kind_in = KIND_S1;
                  stage_in = STAGE_COUNT;
               end else if (item.character == CHAR_9) begin
                  kind_in = KIND_S9;
                  stage_in = STAGE_COUNT;
               end else begin
                  failed_in = 1'b1;
               end
            end else if (!hex_ok) begin
               failed_in = 1'b1;
               pending_in = 1'b0;
            end else if (!pending_ff) begin
               nibble_in = hex_val;
               pending_in = 1'b1;
            end else begin
               pending_in = 1'b0;
               unique case (stage_ff)
                  STAGE_COUNT: begin
                     length_in = byte_val;
                     sum_in = byte_val;
                     seen_in = 2'd0;
                     addr_in = '0;
                     stage_in = STAGE_ADDR;
                  end
                  STAGE_ADDR: begin
                     sum_in = sum_ff + byte_val;
                     addr_in = {addr_ff[7:0], byte_val};
                     if (seen_ff == 2'd0) begin
                        seen_in = 2'd1;
                     end else begin
                        seen_in = 2'd2;
                        if (kind_ff == KIND_S1) begin
                           left_in = left_next;
                           stage_in = (left_next != '0) ? STAGE_DATA : STAGE_CHECK;
                        end else begin
                           stage_in = STAGE_CHECK;
                        end
                     end
                  end
                  STAGE_DATA: begin
                     sum_in = sum_ff + byte_val;
                     addr_in = addr_ff + 16'd1;
                     left_in = left_ff - 8'd1;
                     if (left_ff == 8'd1) begin
                        stage_in = STAGE_CHECK;
                     end
                  end
                  STAGE_CHECK: begin
                     if (~sum_ff != byte_val) begin
                        failed_in = 1'b1;
                     end else begin
                        stage_in = STAGE_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      res_valid = 1'b0;
      res_item = '0;
      if (char_step && is_eol && (pos_ff != '0)) begin
         if (line_bad) begin
            res_valid = 1'b1;
            res_item.event_res = EV_FAIL;
         end else if ((kind_ff == KIND_S0) || (kind_ff == KIND_S1)) begin
            res_valid = 1'b1;
            res_item.event_res = EV_ACK;
         end else if (kind_ff == KIND_S9) begin
            res_valid = 1'b1;
            res_item.event_res = EV_OK;
            res_item.entry_address = addr_ff;
         end
      end else if (byte_done && (stage_ff == STAGE_DATA)) begin
         res_valid = 1'b1;
         res_item.event_res = EV_WRITE;
         res_item.write_address = addr_ff;
         res_item.write_data = byte_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         pos_ff <= '0;
         stage_ff <= STAGE_S;
         kind_ff <= KIND_S0;
         nibble_ff <= '0;
         pending_ff <= 1'b0;
         length_ff <= '0;
         sum_ff <= '0;
         addr_ff <= '0;
         left_ff <= '0;
         seen_ff <= '0;
         failed_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         pos_ff <= pos_in;
         stage_ff <= stage_in;
         kind_ff <= kind_in;
         nibble_ff <= nibble_in;
         pending_ff <= pending_in;
         length_ff <= length_in;
         sum_ff <= sum_in;
         addr_ff <= addr_in;
         left_ff <= left_in;
         seen_ff <= seen_in;
         failed_ff <= failed_in;
      end
   end

   `ASSERT_SAME(a_idle_silent, clock, reset, step && !active_ff, !res_valid,
      "Inactive loader produced a result item.")
   `ASSERT_SAME(a_write_in_data, clock, reset,
      res_valid && (res_item.event_res == EV_WRITE), stage_ff == STAGE_DATA,
      "Byte write outside the data field.")
   `ASSERT_NEXT(a_start_rearms, clock, reset, is_start,
      active_ff && (pos_ff == '0) && (stage_ff == STAGE_S),
      "Start item did not rearm the loader.")
   `ASSERT_SAME(a_pos_limit, clock, reset, 1'b1, pos_ff <= LIMIT_C,
      "Line position beyond the line limit.")

endmodule

FILE: rtl/srec_out_stage.sv
// ----------------------------------------------------------------------------
// S-record loader result register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module srec_out_stage import srec_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  logic         load_valid,
   input  rsp_item_type load_item,
   output logic         free,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign free = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_item = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = load_valid;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         item_ff <= load_item;
      end
   end

endmodule

FILE: rtl/srecord_s19_stream_loader.sv
// ----------------------------------------------------------------------------
// S-record stream loader
// Parses S19 text one character per item and reports writes and verdicts.
//
//   channel  direction  payload         handshake
//   req      in         req_item_type   req_valid / req_ready
//   rsp      out        rsp_item_type   rsp_valid / rsp_ready
//
// One item is taken every cycle unless a stalled result holds the flow; its
// result, if any, enters the result register as the parser consumes the item.
// The rate is set by the single parser step between the two registers.
// Synchronous reset empties both registers and rearms the loader.
// A stalled result holds the parser, and the input register then fills.
// ----------------------------------------------------------------------------
module srecord_s19_stream_loader import srec_pkg::*; #(
   parameter int LINE_LIMIT = LINE_LIMIT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   logic         held_valid;
   req_item_type held_item;
   logic         out_free;
   logic         consume;
   logic         res_valid;
   rsp_item_type res_item;

   assign consume = held_valid && out_free;

   srec_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .consume    (consume),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   srec_parser #(
      .LINE_LIMIT (LINE_LIMIT)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (consume),
      .item      (held_item),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   srec_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (consume),
      .load_valid (res_valid),
      .load_item  (res_item),
      .free       (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule
